// File: sv/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types and constants of the segmented binary loader.
// ----------------------------------------------------------------------------
package sbl_pkg;

  localparam logic [15:0] SIGNATURE = 16'hFFFF;

  typedef enum logic [7:0] {
    PH_SIG_LO   = 8'b0000_0001,
    PH_SIG_HI   = 8'b0000_0010,
    PH_FIRST_LO = 8'b0000_0100,
    PH_FIRST_HI = 8'b0000_1000,
    PH_LAST_LO  = 8'b0001_0000,
    PH_LAST_HI  = 8'b0010_0000,
    PH_DATA     = 8'b0100_0000,
    PH_IGNORE   = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_BADSIG = 2'd2,
    KIND_TRUNC  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] bytes_consumed;
  } result_t;

endpackage

// File: sv/sbl_fsm.sv
// ----------------------------------------------------------------------------
// sbl_fsm
// Load file parser: holds the header and block state, takes one byte or end
// marker per enabled cycle and produces at most one result.
// ----------------------------------------------------------------------------
module sbl_fsm import sbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_end_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  sig_low_q, sig_low_d;
  logic [15:0] first_q, first_d;
  logic [7:0]  last_low_q, last_low_d;
  logic [15:0] next_addr_q, next_addr_d;
  logic [16:0] bytes_left_q, bytes_left_d;
  logic        until_end_q, until_end_d;
  logic [15:0] count_q, count_d;

  logic [16:0] last_plus;
  logic [16:0] span;
  logic [15:0] count_inc;

  assign last_plus = {1'b0, data_byte_i, last_low_q} + 17'd1;
  assign span      = last_plus - {1'b0, first_q};
  assign count_inc = count_q + 16'd1;

  always_comb begin
    phase_d      = phase_q;
    sig_low_d    = sig_low_q;
    first_d      = first_q;
    last_low_d   = last_low_q;
    next_addr_d  = next_addr_q;
    bytes_left_d = bytes_left_q;
    until_end_d  = until_end_q;
    count_d      = count_q;
    res_valid_o  = 1'b0;
    res_o        = '{kind: KIND_WRITE, write_address: 16'd0, write_data: 8'd0,
                     bytes_consumed: count_q};

    if (is_end_i) begin
      if (phase_q == PH_FIRST_LO || phase_q == PH_FIRST_HI) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_DONE;
      end else if (phase_q != PH_IGNORE) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_TRUNC;
      end
      phase_d      = PH_SIG_LO;
      sig_low_d    = 8'd0;
      first_d      = 16'd0;
      last_low_d   = 8'd0;
      next_addr_d  = 16'd0;
      bytes_left_d = 17'd0;
      until_end_d  = 1'b0;
      count_d      = 16'd0;
    end else if (phase_q != PH_IGNORE) begin
      count_d              = count_inc;
      res_o.bytes_consumed = count_inc;
      case (phase_q)
        PH_SIG_LO: begin
          sig_low_d = data_byte_i;
          phase_d   = PH_SIG_HI;
        end
        PH_SIG_HI: begin
          if ({data_byte_i, sig_low_q} != SIGNATURE) begin
            phase_d     = PH_IGNORE;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_BADSIG;
          end else begin
            phase_d = PH_FIRST_LO;
          end
        end
        PH_FIRST_LO: begin
          first_d = {8'd0, data_byte_i};
          phase_d = PH_FIRST_HI;
        end
        PH_FIRST_HI: begin
          first_d = {data_byte_i, first_q[7:0]};
          phase_d = PH_LAST_LO;
        end
        PH_LAST_LO: begin
          last_low_d = data_byte_i;
          phase_d    = PH_LAST_HI;
        end
        PH_LAST_HI: begin
          next_addr_d = first_q;
          if (last_plus < {1'b0, first_q}) begin
            until_end_d  = 1'b1;
            bytes_left_d = 17'd0;
            phase_d      = PH_DATA;
          end else begin
            until_end_d  = 1'b0;
            bytes_left_d = span;
            phase_d      = (span == 17'd0) ? PH_FIRST_LO : PH_DATA;
          end
        end
        PH_DATA: begin
          res_valid_o         = 1'b1;
          res_o.kind          = KIND_WRITE;
          res_o.write_address = next_addr_q;
          res_o.write_data    = data_byte_i;
          next_addr_d         = next_addr_q + 16'd1;
          if (!until_end_q) begin
            bytes_left_d = bytes_left_q - 17'd1;
            if (bytes_left_q == 17'd1) begin
              phase_d = PH_FIRST_LO;
            end
          end
        end
        default: begin
          phase_d = PH_SIG_LO;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SIG_LO;
      sig_low_q    <= 8'd0;
      first_q      <= 16'd0;
      last_low_q   <= 8'd0;
      next_addr_q  <= 16'd0;
      bytes_left_q <= 17'd0;
      until_end_q  <= 1'b0;
      count_q      <= 16'd0;
    end else if (en_i) begin
      phase_q      <= phase_d;
      sig_low_q    <= sig_low_d;
      first_q      <= first_d;
      last_low_q   <= last_low_d;
      next_addr_q  <= next_addr_d;
      bytes_left_q <= bytes_left_d;
      until_end_q  <= until_end_d;
      count_q      <= count_d;
    end
  end

endmodule

// File: sv/segmented_binary_loader.sv
// ----------------------------------------------------------------------------
// segmented_binary_loader
// Parses a segmented load file byte by byte and emits memory write requests
// and end-of-file status.
// ----------------------------------------------------------------------------
// path: input register, parser step, output register; throughput: one input
//   request per cycle while the output is not stalled, set by the single
//   parser step between the input register and the output register
// reset: asynchronous, clears the parser to the signature state and empties
//   both register stages
module segmented_binary_loader import sbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,   // is_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // write_address[15:0], write_data[23:16],
                                      // bytes_consumed[39:24]
  output logic [1:0]  m_axis_tuser    // kind[1:0]
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       out_vld_q, out_vld_d;
  result_t    out_res_q;
  logic       advance;
  logic       res_valid;
  result_t    res;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  sbl_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .data_byte_i(in_byte_q),
    .is_end_i   (in_end_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tready) begin
      in_vld_d = s_axis_tvalid;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = res_valid;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.kind;
  assign m_axis_tdata  = {out_res_q.bytes_consumed, out_res_q.write_data,
                          out_res_q.write_address};

endmodule

// File: dv/segmented_binary_loader_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segmented_binary_loader_checker
// Watches both stream channels of the loader, keeps its own copy of the file
// parser, queues the result each accepted request should give and compares
// every result that leaves the block, field by field, against the oldest one.
// ----------------------------------------------------------------------------
module segmented_binary_loader_checker import sbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count,
  output int          pending
);

  phase_e      phase_q;
  logic [7:0]  sig_lo_q;
  logic [7:0]  last_lo_q;
  logic [15:0] first_q;
  logic [15:0] addr_q;
  logic [15:0] count_q;
  logic [16:0] remaining_q;
  logic        open_ended_q;

  result_t     loads_expected[$];
  logic        has_result;
  result_t     predicted;
  result_t     want;

  task automatic clear_parser();
    phase_q      = PH_SIG_LO;
    sig_lo_q     = '0;
    last_lo_q    = '0;
    first_q      = '0;
    addr_q       = '0;
    count_q      = '0;
    remaining_q  = '0;
    open_ended_q = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic is_end,
                            output logic emit, output result_t r);
    logic [16:0] last_plus;
    emit = 1'b0;
    r    = '0;
    if (is_end) begin
      if (phase_q == PH_FIRST_LO || phase_q == PH_FIRST_HI) begin
        emit   = 1'b1;
        r.kind = KIND_DONE;
      end else if (phase_q != PH_IGNORE) begin
        emit   = 1'b1;
        r.kind = KIND_TRUNC;
      end
      r.bytes_consumed = count_q;
      clear_parser();
    end else if (phase_q != PH_IGNORE) begin
      count_q = count_q + 16'd1;
      case (phase_q)
        PH_SIG_LO: begin
          sig_lo_q = b;
          phase_q  = PH_SIG_HI;
        end
        PH_SIG_HI: begin
          if ({b, sig_lo_q} != SIGNATURE) begin
            phase_q = PH_IGNORE;
            emit    = 1'b1;
            r.kind  = KIND_BADSIG;
          end else begin
            phase_q = PH_FIRST_LO;
          end
        end
        PH_FIRST_LO: begin
          first_q = {8'h00, b};
          phase_q = PH_FIRST_HI;
        end
        PH_FIRST_HI: begin
          first_q[15:8] = b;
          phase_q       = PH_LAST_LO;
        end
        PH_LAST_LO: begin
          last_lo_q = b;
          phase_q   = PH_LAST_HI;
        end
        PH_LAST_HI: begin
          last_plus = {1'b0, b, last_lo_q} + 17'd1;
          addr_q    = first_q;
          if (last_plus < {1'b0, first_q}) begin
            // reversed range: data runs up to the end marker
            open_ended_q = 1'b1;
            remaining_q  = '0;
            phase_q      = PH_DATA;
          end else begin
            open_ended_q = 1'b0;
            remaining_q  = last_plus - {1'b0, first_q};
            if (remaining_q == '0) begin
              phase_q = PH_FIRST_LO;
            end else begin
              phase_q = PH_DATA;
            end
          end
        end
        default: begin
          emit            = 1'b1;
          r.kind          = KIND_WRITE;
          r.write_address = addr_q;
          r.write_data    = b;
          addr_q          = addr_q + 16'd1;
          if (!open_ended_q) begin
            remaining_q = remaining_q - 17'd1;
            if (remaining_q == '0) begin
              phase_q = PH_FIRST_LO;
            end
          end
        end
      endcase
      r.bytes_consumed = count_q;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      loads_expected.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast, has_result, predicted);
        if (has_result) begin
          loads_expected.push_back(predicted);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (loads_expected.size() == 0) begin
          $error("unexpected result: kind %0d address %h data %h count %0d",
                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16],
                 m_axis_tdata[39:24]);
          fail_count++;
        end else begin
          want = loads_expected.pop_front();
          if (m_axis_tuser != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[15:0] != want.write_address) begin
            $error("write_address: expected %h, got %h", want.write_address,
                   m_axis_tdata[15:0]);
            fail_count++;
          end
          if (m_axis_tdata[23:16] != want.write_data) begin
            $error("write_data: expected %h, got %h", want.write_data,
                   m_axis_tdata[23:16]);
            fail_count++;
          end
          if (m_axis_tdata[39:24] != want.bytes_consumed) begin
            $error("bytes_consumed: expected %0d, got %0d", want.bytes_consumed,
                   m_axis_tdata[39:24]);
            fail_count++;
          end
        end
      end
      pending = loads_expected.size();
    end
  end

endmodule

// File: dv/segmented_binary_loader_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segmented_binary_loader_tb
// Feeds the loader hand-written load files covering signature, empty, full,
// reversed and wrapping blocks and every kind of end, then random files of
// at least 600 items in all, mostly well formed, with random idle on both
// channels and a long output stall; the checker judges every result.
// ----------------------------------------------------------------------------
module segmented_binary_loader_tb;
  import sbl_pkg::*;

  localparam int          LATENCY      = 2;
  localparam int          RANDOM_ITEMS = 600;
  localparam int          HOLD_CYCLES  = 200;
  localparam logic [8:0]  END_MARK     = 9'h100;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int fail_count;
  int pending;
  int src_idle_pct = 33;
  int snk_idle_pct = 79;
  int items_sent   = 0;
  int holds_asked  = 0;
  int holds_done   = 0;

  // empty block, full block, reversed block with address wrap, bad signature,
  // clean end inside the first address
  logic [8:0] directed_files[$] = '{
    9'hFF, 9'hFF, 9'h34, 9'h12, 9'h33, 9'h12, 9'h00, 9'h00, 9'hFF, 9'hFF,
    9'h00, 9'hFF, END_MARK,
    9'hFF, 9'hFF, 9'hFF, 9'hFF, 9'h00, 9'h00, 9'hFF, 9'h00, END_MARK,
    9'hFF, 9'h7F, 9'h12, END_MARK,
    9'hFF, 9'hFF, 9'h00, END_MARK
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segmented_binary_loader i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  segmented_binary_loader_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // receiver side
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic is_end);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_end;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_header(input logic [15:0] first, input logic [15:0] last);
    send_item(first[7:0], 1'b0);
    send_item(first[15:8], 1'b0);
    send_item(last[7:0], 1'b0);
    send_item(last[15:8], 1'b0);
  endtask

  task automatic send_good_file(input int blocks_max, input int size_min,
                                input int size_max);
    int          size;
    int          n;
    logic [15:0] first;
    logic [15:0] last;
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    repeat ($urandom_range(1, blocks_max)) begin
      size = $urandom_range(size_min, size_max);
      if ($urandom_range(0, 9) == 0) begin
        size = 0;
      end
      first = 16'($urandom_range(1, 65535 - size));
      last  = 16'(first + size - 1);
      send_header(first, last);
      repeat (size) send_item(8'($urandom), 1'b0);
    end
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        // partial header: clean end after one byte, truncated after more
        repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
      end
      2: begin
        size  = $urandom_range(2, 8);
        first = 16'($urandom_range(1, 65535 - size));
        last  = 16'(first + size - 1);
        send_header(first, last);
        repeat ($urandom_range(0, size - 1)) send_item(8'($urandom), 1'b0);
      end
      default: begin
        first = 16'($urandom_range(2, 65535));
        last  = 16'($urandom_range(0, first - 2));
        send_header(first, last);
        n = $urandom_range(0, 6);
        repeat (n) send_item(8'($urandom), 1'b0);
      end
    endcase
    send_item(8'($urandom), 1'b1);
  endtask

  initial begin
    int          base;
    int          stage;
    int          last_stage;
    logic [7:0]  sig_lo;
    logic [7:0]  sig_hi;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_files[i]) begin
      send_item(directed_files[i][7:0], directed_files[i][8]);
    end
    drain();

    // long output stall while the sender keeps offering a large block
    src_idle_pct = 0;
    holds_asked++;
    send_good_file(2, 30, 40);
    drain();

    base       = items_sent;
    last_stage = -1;
    while (items_sent - base < RANDOM_ITEMS) begin
      stage = (items_sent - base) / 200;
      if (stage != last_stage) begin
        drain();
        last_stage = stage;
        case (stage)
          0: begin
            src_idle_pct = 33;
            snk_idle_pct = 79;
          end
          1: begin
            src_idle_pct = 79;
            snk_idle_pct = 33;
          end
          default: begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
          end
        endcase
      end
      n_mode: case ($urandom_range(0, 99) / 10)
        0: begin
          // bad signature, trailing bytes ignored
          sig_lo = 8'($urandom);
          sig_hi = 8'($urandom);
          if ($urandom_range(0, 1) == 0) begin
            sig_lo = 8'hFF;
          end
          if ({sig_hi, sig_lo} == SIGNATURE) begin
            sig_hi = 8'($urandom_range(0, 254));
          end
          send_item(sig_lo, 1'b0);
          send_item(sig_hi, 1'b0);
          repeat ($urandom_range(0, 4)) send_item(8'($urandom), 1'b0);
          send_item(8'($urandom), 1'b1);
        end
        1: begin
          repeat ($urandom_range(1, 6)) begin
            send_item(8'($urandom), ($urandom_range(0, 4) == 0));
          end
          send_item(8'($urandom), 1'b1);
        end
        default: send_good_file(3, 1, 12);
      endcase
    end

    drain();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
